@@ hdl/assert_macros.svh @@
// assertion helpers shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted, with its own message
`define AST_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check with a generic message
`define AST_CHK(lbl, clk, rstn, prop) \
  `AST_MSG(lbl, clk, rstn, prop, "allocator check failed")

`endif

@@ hdl/ffra_pkg.sv @@
package ffra_pkg;

  // sizes fixed by the field layout
  localparam int unsigned SIZE_W  = 33;
  localparam int unsigned OFFS_W  = 32;
  localparam int unsigned ORDER_W = 6;

  localparam int unsigned MAX_REGIONS_DEF = 64;
  localparam logic [ORDER_W-1:0] RESET_ORDER = 6'd26;
  localparam int unsigned ORDER_MIN = 4;
  localparam int unsigned ORDER_MAX = 32;

  // result codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVER_FREE = 3'd1,
    ST_NO_GAP    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ZERO      = 3'd5
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_CHECK,
    FSM_SCAN,
    FSM_SHIFT_UP,
    FSM_PLACE,
    FSM_SEARCH,
    FSM_SHIFT_DN,
    FSM_FINISH
  } state_t;

  // table walk index moves
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLEAR,
    IDX_INC,
    IDX_DEC,
    IDX_LAST
  } idx_op_t;

  typedef struct packed {
    logic    cfg_write;
    logic    load_req;
    idx_op_t idx_op;
    logic    cursor_adv;
    logic    set_ins;
    logic    wr_up;
    logic    wr_dn;
    logic    place;
    logic    release_hit;
    logic    count_dec;
    logic    set_status;
    status_t status;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_release;
    logic zero_size;
    logic over_free;
    logic full;
    logic at_end;
    logic gap_fit;
    logic tail_fit;
    logic hit;
    logic last_entry;
    logic at_ins;
  } dp_stat_t;

  // heap size in bytes for a register value, order clamped to its range
  function automatic logic [SIZE_W-1:0] heap_size(input logic [ORDER_W-1:0] ord);
    logic [ORDER_W-1:0] o;
    begin
      o = ord;
      if (o < ORDER_W'(ORDER_MIN)) o = ORDER_W'(ORDER_MIN);
      if (o > ORDER_W'(ORDER_MAX)) o = ORDER_W'(ORDER_MAX);
      return SIZE_W'(1) << o;
    end
  endfunction

endpackage

@@ hdl/ffra_datapath.sv @@
`include "assert_macros.svh"

module ffra_datapath #(
  parameter int unsigned MAX_REGIONS = ffra_pkg::MAX_REGIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ffra_pkg::ORDER_W-1:0]    cfg_data,
  input  logic                            in_command,
  input  logic [ffra_pkg::SIZE_W-1:0]     in_size,
  input  logic [ffra_pkg::OFFS_W-1:0]     in_offset,
  input  ffra_pkg::dp_cmd_t               cmd,
  output ffra_pkg::dp_stat_t              stat,
  output ffra_pkg::status_t               out_status,
  output logic [ffra_pkg::OFFS_W-1:0]     out_offset,
  output logic [ffra_pkg::SIZE_W-1:0]     out_free
);

  localparam int unsigned AW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW  = $clog2(MAX_REGIONS + 1);
  localparam int unsigned SW  = ffra_pkg::SIZE_W;
  localparam int unsigned OW  = ffra_pkg::OFFS_W;
  localparam int unsigned EW  = OW + SW;
  localparam int unsigned XW  = SW + 1;

  // region table: start in the upper bits, length in the lower bits
  logic [EW-1:0] mem [MAX_REGIONS];
  logic [EW-1:0] rdata_r;

  logic [ffra_pkg::ORDER_W-1:0] order_r;
  logic [SW-1:0]                free_r;
  logic [CW-1:0]                count_r;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [CW-1:0]                ins_r;
  logic [XW-1:0]                cursor_r;
  logic                         req_cmd_r;
  logic [SW-1:0]                req_size_r;
  logic [OW-1:0]                req_offs_r;
  ffra_pkg::status_t            status_r;
  logic [OW-1:0]                where_r;
  ffra_pkg::status_t            out_status_r;
  logic [OW-1:0]                out_offset_r;
  logic [SW-1:0]                out_free_r;

  logic [OW-1:0] ent_start;
  logic [SW-1:0] ent_len;
  logic [XW-1:0] start_x, total_x, size_x;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [OW-1:0] where_val;

  assign ent_start = rdata_r[EW-1:SW];
  assign ent_len   = rdata_r[SW-1:0];
  assign start_x   = XW'(ent_start);
  assign total_x   = {1'b0, ffra_pkg::heap_size(order_r)};
  assign size_x    = {1'b0, req_size_r};

  // index moves for the table walk
  always_comb begin
    case (cmd.idx_op)
      ffra_pkg::IDX_CLEAR: idx_nxt = '0;
      ffra_pkg::IDX_INC:   idx_nxt = idx_r + CW'(1);
      ffra_pkg::IDX_DEC:   idx_nxt = idx_r - CW'(1);
      ffra_pkg::IDX_LAST:  idx_nxt = count_r - CW'(1);
      default:             idx_nxt = idx_r;
    endcase
  end

  // status toward the controller
  always_comb begin
    stat.is_release = req_cmd_r;
    stat.zero_size  = (req_size_r == '0);
    stat.over_free  = (req_size_r > free_r);
    stat.full       = (count_r >= CW'(MAX_REGIONS));
    stat.at_end     = (idx_r == count_r);
    stat.gap_fit    = (start_x >= cursor_r) && ((start_x - cursor_r) >= size_x);
    stat.tail_fit   = !(cursor_r > total_x) && !(size_x > (total_x - cursor_r));
    stat.hit        = (ent_start == req_offs_r);
    stat.last_entry = ((idx_r + CW'(1)) == count_r);
    stat.at_ins     = (idx_r == ins_r);
  end

  // table write port: shift up, shift down or new entry
  always_comb begin
    wr_en   = cmd.wr_up | cmd.wr_dn | cmd.place;
    wr_addr = ins_r[AW-1:0];
    wr_data = {cursor_r[OW-1:0], req_size_r};
    if (cmd.wr_up) begin
      wr_addr = AW'(idx_r + CW'(1));
      wr_data = rdata_r;
    end else if (cmd.wr_dn) begin
      wr_addr = AW'(idx_r - CW'(1));
      wr_data = rdata_r;
    end
  end

  // look-ahead read so that rdata_r holds the entry at idx_r
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[idx_nxt[AW-1:0]];
  end

  // offset reported with the result
  always_comb begin
    if (req_cmd_r) begin
      where_val = req_offs_r;
    end else if (cmd.status == ffra_pkg::ST_OK) begin
      where_val = cursor_r[OW-1:0];
    end else begin
      where_val = '0;
    end
  end

  // heap state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ffra_pkg::RESET_ORDER;
      free_r  <= ffra_pkg::heap_size(ffra_pkg::RESET_ORDER);
      count_r <= '0;
    end else if (cmd.cfg_write) begin
      order_r <= cfg_data;
      free_r  <= ffra_pkg::heap_size(cfg_data);
      count_r <= '0;
    end else begin
      if (cmd.place) begin
        free_r  <= free_r - req_size_r;
        count_r <= count_r + CW'(1);
      end
      if (cmd.release_hit) begin
        free_r <= free_r + ent_len;
      end
      if (cmd.count_dec) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // request, walk and result registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_req) begin
      req_cmd_r  <= in_command;
      req_size_r <= in_size;
      req_offs_r <= in_offset;
      cursor_r   <= '0;
    end else if (cmd.cursor_adv) begin
      cursor_r <= start_x + {1'b0, ent_len};
    end
    if (cmd.set_ins) begin
      ins_r <= idx_r;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
      where_r  <= where_val;
    end
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_offset_r <= where_r;
      out_free_r   <= free_r;
    end
  end

  assign out_status = out_status_r;
  assign out_offset = out_offset_r;
  assign out_free   = out_free_r;

  `AST_MSG(a_count_bound, clk, rst_n, count_r <= CW'(MAX_REGIONS),
           "region count over table depth")
  `AST_MSG(a_free_bound, clk, rst_n, free_r <= ffra_pkg::heap_size(order_r),
           "free bytes over heap size")
  `AST_CHK(a_place_count, clk, rst_n, cmd.place |=> (count_r == $past(count_r) + CW'(1)))

endmodule

@@ hdl/ffra_ctrl.sv @@
`include "assert_macros.svh"

module ffra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ffra_pkg::dp_stat_t  stat,
  output ffra_pkg::dp_cmd_t   cmd
);

  ffra_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  // state and output slot registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffra_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.idx_op     = ffra_pkg::IDX_HOLD;
    cmd.status     = ffra_pkg::ST_OK;
    in_tready      = 1'b0;
    cfg_ready      = 1'b0;
    case (state_r)
      ffra_pkg::FSM_IDLE: begin
        cfg_ready = 1'b1;
        in_tready = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
        end else if (in_tvalid) begin
          cmd.load_req = 1'b1;
          cmd.idx_op   = ffra_pkg::IDX_CLEAR;
          state_nxt    = ffra_pkg::FSM_CHECK;
        end
      end
      ffra_pkg::FSM_CHECK: begin
        if (stat.is_release) begin
          state_nxt = ffra_pkg::FSM_SEARCH;
        end else if (stat.zero_size) begin
          cmd.set_status = 1'b1;
          cmd.status     = ffra_pkg::ST_ZERO;
          state_nxt      = ffra_pkg::FSM_FINISH;
        end else if (stat.over_free) begin
          cmd.set_status = 1'b1;
          cmd.status     = ffra_pkg::ST_OVER_FREE;
          state_nxt      = ffra_pkg::FSM_FINISH;
        end else if (stat.full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ffra_pkg::ST_FULL;
          state_nxt      = ffra_pkg::FSM_FINISH;
        end else begin
          state_nxt = ffra_pkg::FSM_SCAN;
        end
      end
      ffra_pkg::FSM_SCAN: begin
        if (stat.at_end) begin
          if (stat.tail_fit) begin
            cmd.set_ins = 1'b1;
            state_nxt   = ffra_pkg::FSM_PLACE;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = ffra_pkg::ST_NO_GAP;
            state_nxt      = ffra_pkg::FSM_FINISH;
          end
        end else if (stat.gap_fit) begin
          cmd.set_ins = 1'b1;
          cmd.idx_op  = ffra_pkg::IDX_LAST;
          state_nxt   = ffra_pkg::FSM_SHIFT_UP;
        end else begin
          cmd.cursor_adv = 1'b1;
          cmd.idx_op     = ffra_pkg::IDX_INC;
        end
      end
      ffra_pkg::FSM_SHIFT_UP: begin
        cmd.wr_up = 1'b1;
        if (stat.at_ins) begin
          state_nxt = ffra_pkg::FSM_PLACE;
        end else begin
          cmd.idx_op = ffra_pkg::IDX_DEC;
        end
      end
      ffra_pkg::FSM_PLACE: begin
        cmd.place      = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = ffra_pkg::ST_OK;
        state_nxt      = ffra_pkg::FSM_FINISH;
      end
      ffra_pkg::FSM_SEARCH: begin
        if (stat.at_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ffra_pkg::ST_NOT_FOUND;
          state_nxt      = ffra_pkg::FSM_FINISH;
        end else if (stat.hit) begin
          cmd.release_hit = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status      = ffra_pkg::ST_OK;
          if (stat.last_entry) begin
            cmd.count_dec = 1'b1;
            state_nxt     = ffra_pkg::FSM_FINISH;
          end else begin
            cmd.idx_op = ffra_pkg::IDX_INC;
            state_nxt  = ffra_pkg::FSM_SHIFT_DN;
          end
        end else begin
          cmd.idx_op = ffra_pkg::IDX_INC;
        end
      end
      ffra_pkg::FSM_SHIFT_DN: begin
        cmd.wr_dn = 1'b1;
        if (stat.last_entry) begin
          cmd.count_dec = 1'b1;
          state_nxt     = ffra_pkg::FSM_FINISH;
        end else begin
          cmd.idx_op = ffra_pkg::IDX_INC;
        end
      end
      ffra_pkg::FSM_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ffra_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = ffra_pkg::FSM_IDLE;
      end
    endcase
  end

  // output slot: filled on load, emptied when the beat is taken
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  `AST_CHK(a_busy_after_accept, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)
  `AST_MSG(a_load_fills_slot, clk, rst_n, cmd.load_out |=> out_tvalid, "result not presented")
  `AST_MSG(a_cfg_not_busy, clk, rst_n, (cfg_valid && cfg_ready) |-> !(in_tvalid && in_tready),
           "config and request taken together")

endmodule

@@ hdl/first_fit_region_allocator.sv @@
// channel   dir  handshake            payload
// in_       in   in_tvalid/tready     tuser: command; tdata: request_size, release_offset
// out_      out  out_tvalid/tready    tuser: status; tdata: region_offset, free_remaining
// cfg_      in   cfg_valid/ready      cfg_data: heap_order
//
// one request at a time over a region table with one write port and one
// registered read port.
// rst_n is synchronous; reset empties the table and sets a 2^26 byte heap.
// a result waits in the output register while the next request is taken;
// a request finishing while that register is still full holds until it drains.
module first_fit_region_allocator #(
  parameter int unsigned MAX_REGIONS = ffra_pkg::MAX_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [32:0] request_size, [64:33] release_offset, zero fill
  input  logic [0:0]  in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] region_offset, [64:32] free_remaining, zero fill
  output logic [2:0]  out_tuser,  // [2:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data    // heap_order
);

  ffra_pkg::dp_cmd_t  cmd;
  ffra_pkg::dp_stat_t stat;
  ffra_pkg::status_t  res_status;
  logic [ffra_pkg::OFFS_W-1:0] res_offset;
  logic [ffra_pkg::SIZE_W-1:0] res_free;

  ffra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ffra_datapath #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_data   (cfg_data),
    .in_command (in_tuser[0]),
    .in_size    (in_tdata[32:0]),
    .in_offset  (in_tdata[64:33]),
    .cmd        (cmd),
    .stat       (stat),
    .out_status (res_status),
    .out_offset (res_offset),
    .out_free   (res_free)
  );

  // result beat packing
  assign out_tdata = {7'd0, res_free, res_offset};
  assign out_tuser = res_status;

endmodule

@@ bench/ffra_checker.sv @@
`timescale 1ns / 1ps

package ffra_tb_pkg;

  // request kinds carried on in_tuser
  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } command_t;

endpackage

module ffra_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,   // [32:0] request_size, [64:33] release_offset, zero fill
  input  logic [0:0]  in_tuser,   // [0] command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,  // [31:0] region_offset, [64:32] free_remaining, zero fill
  input  logic [2:0]  out_tuser,  // [2:0] status
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [5:0]  cfg_data,   // heap_order
  output int          pending,
  output int          fail_count
);

  localparam int DEPTH      = ffra_pkg::MAX_REGIONS_DEF;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    ffra_pkg::status_t status;
    logic [31:0]       offset;
    logic [32:0]       bytes_left;
  } grant_t;

  // shadow of the region table and heap state
  logic [5:0]  order_reg;
  logic [31:0] start_tab [DEPTH];
  logic [32:0] len_tab   [DEPTH];
  int          n_regions;
  logic [32:0] free_now;
  grant_t      grants_due [$];
  int          mismatches;

  assign fail_count = mismatches;

  // heap bytes for a register value, order clamped into its legal range
  function automatic logic [32:0] heap_span(input logic [5:0] ord);
    int unsigned e;
    e = ord;
    if (e < ffra_pkg::ORDER_MIN) e = ffra_pkg::ORDER_MIN;
    if (e > ffra_pkg::ORDER_MAX) e = ffra_pkg::ORDER_MAX;
    return 33'(64'd1 << e);
  endfunction

  function automatic void reinit_heap();
    n_regions = 0;
    free_now  = heap_span(order_reg);
  endfunction

  // first-fit placement or release, updates the shadow table
  function automatic grant_t serve_request(input ffra_tb_pkg::command_t cmd,
                                           input logic [32:0] size,
                                           input logic [31:0] offs);
    grant_t      g;
    logic [33:0] cursor;
    logic [33:0] total;
    int          slot;
    int          i;
    bit          hit;
    g.status = ffra_pkg::ST_OK;
    g.offset = '0;
    hit      = 1'b0;
    slot     = n_regions;
    cursor   = '0;
    total    = {1'b0, heap_span(order_reg)};
    if (cmd == ffra_tb_pkg::CMD_ALLOC) begin
      if (size == '0) begin
        g.status = ffra_pkg::ST_ZERO;
      end else if (size > free_now) begin
        g.status = ffra_pkg::ST_OVER_FREE;
      end else if (n_regions >= DEPTH) begin
        g.status = ffra_pkg::ST_FULL;
      end else begin
        // walk the sorted table for the first gap that holds the request
        for (i = 0; i < n_regions; i++) begin
          if (!hit) begin
            if ({2'b00, start_tab[i]} >= cursor &&
                {2'b00, start_tab[i]} - cursor >= {1'b0, size}) begin
              hit  = 1'b1;
              slot = i;
            end else begin
              cursor = {2'b00, start_tab[i]} + {1'b0, len_tab[i]};
            end
          end
        end
        if (!hit && (cursor > total || {1'b0, size} > total - cursor)) begin
          g.status = ffra_pkg::ST_NO_GAP;
        end else begin
          for (i = n_regions; i > slot; i--) begin
            start_tab[i] = start_tab[i-1];
            len_tab[i]   = len_tab[i-1];
          end
          start_tab[slot] = cursor[31:0];
          len_tab[slot]   = size;
          n_regions++;
          free_now = free_now - size;
          g.offset = cursor[31:0];
        end
      end
    end else begin
      for (i = 0; i < n_regions; i++) begin
        if (!hit && start_tab[i] == offs) begin
          hit  = 1'b1;
          slot = i;
        end
      end
      g.offset = offs;
      if (!hit) begin
        g.status = ffra_pkg::ST_NOT_FOUND;
      end else begin
        free_now = free_now + len_tab[slot];
        for (i = slot; i + 1 < n_regions; i++) begin
          start_tab[i] = start_tab[i+1];
          len_tab[i]   = len_tab[i+1];
        end
        n_regions--;
      end
    end
    g.bytes_left = free_now;
    return g;
  endfunction

  // follow every beat: config, results against the oldest grant, then requests
  always @(posedge clk) begin : track
    grant_t      want;
    logic [2:0]  got_status;
    logic [31:0] got_offset;
    logic [32:0] got_free;
    if (!rst_n) begin
      order_reg = ffra_pkg::RESET_ORDER;
      reinit_heap();
      grants_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        order_reg = cfg_data;
        reinit_heap();
      end
      if (out_tvalid && out_tready) begin
        got_status = out_tuser;
        got_offset = out_tdata[31:0];
        got_free   = out_tdata[64:32];
        if (grants_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result beat: status %0d offset %h free %h",
                     got_status, got_offset, got_free);
        end else begin
          want = grants_due.pop_front();
          if (got_status != want.status || got_offset != want.offset ||
              got_free != want.bytes_left) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch: exp st %0d off %h free %h, got st %0d off %h free %h",
                       want.status, want.offset, want.bytes_left,
                       got_status, got_offset, got_free);
          end
        end
      end
      if (in_tvalid && in_tready)
        grants_due.push_back(serve_request(ffra_tb_pkg::command_t'(in_tuser[0]),
                                           in_tdata[32:0], in_tdata[64:33]));
    end
    pending <= grants_due.size();
  end

endmodule

@@ bench/tb_first_fit_region_allocator.sv @@
`timescale 1ns / 1ps

module tb_first_fit_region_allocator;

  localparam int NUM_PHASES      = 11;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int PRESSURE_PHASE  = 1;
  localparam int HOLD_CYCLES     = 600;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int RESET_CYCLES    = 6;
  localparam int POOL_MAX        = 200;
  // heap orders per phase, phase 0 in the lowest bits
  localparam logic [6*NUM_PHASES-1:0] PHASE_ORDERS = {
    6'd3, 6'd33, 6'd20, 6'd7, 6'd12, 6'd0, 6'd63, 6'd32, 6'd4, 6'd26, 6'd7
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // [32:0] request_size, [64:33] release_offset, zero fill
  logic [0:0]  in_tuser;   // [0] command
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // [31:0] region_offset, [64:32] free_remaining, zero fill
  logic [2:0]  out_tuser;  // [2:0] status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_data;   // heap_order

  int          pending_cnt;
  int          fail_cnt;
  logic [5:0]  cur_order;
  logic [31:0] live_offsets [$];
  bit          pressure_go;
  bit          pressure_done;
  int          quiet_cycles;

  first_fit_region_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  ffra_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (pending_cnt),
    .fail_count (fail_cnt)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // one request beat, with in_tvalid low for the given gap first
  task automatic send_req(input ffra_tb_pkg::command_t cmd, input logic [32:0] size,
                          input logic [31:0] offs, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, offs, size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic req_alloc(input logic [32:0] size);
    send_req(ffra_tb_pkg::CMD_ALLOC, size, $urandom, 0);
  endtask

  task automatic req_free(input logic [31:0] offs);
    send_req(ffra_tb_pkg::CMD_RELEASE, 33'({$urandom_range(0, 1), $urandom}), offs, 0);
  endtask

  // wait for all results, then reinitialize the heap at a new order
  task automatic write_order(input logic [5:0] ord);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ord;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_order = ord;
    live_offsets.delete();
  endtask

  // random request: mostly sane sizes and known offsets, some noise
  task automatic random_request(input int alloc_pct, input logic [63:0] small_max,
                                input logic [63:0] heap, input bit tight);
    ffra_tb_pkg::command_t cmd;
    logic [32:0] sz;
    logic [31:0] offs;
    int          pick;
    int          idx;
    sz   = 33'({$urandom_range(0, 1), $urandom});
    offs = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      cmd  = ffra_tb_pkg::CMD_ALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 4)
        sz = '0;
      else if (pick < 8)
        sz = 33'({$urandom_range(0, 1), $urandom});
      else if (pick < 12)
        sz = 33'(heap - $urandom_range(0, 2));
      else if (pick < 20)
        sz = 33'(64'd1 + {32'd0, $urandom} % (heap >> 1));
      else
        sz = 33'(64'd1 + {32'd0, $urandom} % small_max);
    end else begin
      cmd = ffra_tb_pkg::CMD_RELEASE;
      if (live_offsets.size() > 0 && $urandom_range(0, 9) < 8) begin
        idx  = $urandom_range(0, live_offsets.size() - 1);
        offs = live_offsets[idx];
        live_offsets.delete(idx);
      end
    end
    send_req(cmd, sz, offs, tight ? 0 : pick_gap());
  endtask

  // collect granted offsets so releases can name live regions
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tuser == ffra_pkg::ST_OK) begin
      live_offsets.push_back(out_tdata[31:0]);
      if (live_offsets.size() > POOL_MAX) void'(live_offsets.pop_front());
    end
  end

  // result side: random stalls, calm stretches, one long hold-off
  initial begin : sink
    int stall_left;
    int mode_left;
    bit no_stall;
    out_tready    = 1'b0;
    pressure_done = 1'b0;
    stall_left    = 0;
    mode_left     = 0;
    no_stall      = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        no_stall  = ($urandom_range(0, 2) == 0);
        mode_left = 300;
      end
      mode_left--;
      if (pressure_go && !pressure_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        pressure_done = 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!no_stall && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                 : $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_first_fit_region_allocator failed");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin : stim
    int          p;
    int unsigned eff;
    logic [63:0] heap;
    logic [63:0] small_max;
    int          alloc_pct;
    bit          tight;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    pressure_go = 1'b0;
    cur_order   = ffra_pkg::RESET_ORDER;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: error codes, whole heap, gaps and tail at the reset order
    req_alloc(33'd0);
    req_alloc(33'h1_FFFF_FFFF);
    req_free(32'd0);
    req_free(32'hFFFF_FFFF);
    req_alloc(33'd1 << 26);
    req_alloc(33'd1);
    req_free(32'd0);
    req_alloc(33'd100);
    req_alloc(33'd200);
    req_alloc(33'd300);
    req_free(32'd100);
    req_alloc(33'd250);
    req_alloc(33'd150);
    req_alloc((33'd1 << 26) - 33'd800);
    req_free(32'd300);
    req_alloc(33'd50);
    req_free(32'd600);
    // largest heap taken whole and given back
    write_order(6'd32);
    req_alloc(33'h1_0000_0000);
    req_alloc(33'h1_0000_0000);
    req_free(32'd0);
    req_alloc(33'h1_0000_0001);

    // random phases over several heap orders
    for (p = 0; p < NUM_PHASES; p++) begin
      write_order(PHASE_ORDERS[p*6 +: 6]);
      eff = cur_order;
      if (eff < ffra_pkg::ORDER_MIN) eff = ffra_pkg::ORDER_MIN;
      if (eff > ffra_pkg::ORDER_MAX) eff = ffra_pkg::ORDER_MAX;
      heap = 64'd1 << eff;
      // at order 7, one-byte allocations fill the table; smaller heaps get small sizes
      if (eff <= 7) begin
        small_max = (eff == 7) ? 64'd1 : 64'd3;
        alloc_pct = (eff == 7) ? 98 : 55;
      end else begin
        small_max = heap >> 4;
        alloc_pct = 60;
      end
      tight = (p == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
      if (p == PRESSURE_PHASE) pressure_go = 1'b1;
      repeat (ITEMS_PER_PHASE) random_request(alloc_pct, small_max, heap, tight);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0)
      $display("tb_first_fit_region_allocator passed");
    else
      $display("tb_first_fit_region_allocator failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/ffra_pkg.sv
hdl/ffra_datapath.sv
hdl/ffra_ctrl.sv
hdl/first_fit_region_allocator.sv
bench/ffra_checker.sv
bench/tb_first_fit_region_allocator.sv
